// ===== src/sdot_pkg.sv =====
// ----------------------------------------------------------------------------
// sdot_pkg: shared constants and helpers
// Widths, register indexes and saturation for the averaged OT SGD block.
// ----------------------------------------------------------------------------
package sdot_pkg;

   localparam int DEF_ROWS        = 16;
   localparam int DEF_MAX_COLUMNS = 1048576;

   localparam int VAL_W  = 32;  // Q16.16 values
   localparam int GAIN_W = 24;  // step gain, Q8.16
   localparam int RIU_W  = 5;   // rows_in_use register
   localparam int CSR_W  = 24;  // widest register
   localparam int IDX_W  = 2;   // CSR index
   localparam int DIV_W  = 48;  // divider dividend / quotient
   localparam int DVR_W  = 24;  // divider divisor

   localparam logic [IDX_W-1:0] CSR_STEP_GAIN   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_ROWS_IN_USE = 2'd1;

   function automatic logic [VAL_W-1:0] sat32(input logic signed [33:0] x);
      logic [VAL_W-1:0] res;
      if (x > 34'sh0_7FFF_FFFF)       res = 32'h7FFF_FFFF;
      else if (x < -34'sh0_8000_0000) res = 32'h8000_0000;
      else                            res = x[31:0];
      return res;
   endfunction

endpackage

// ===== src/sdot_ram.sv =====
// ----------------------------------------------------------------------------
// sdot_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sdot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sdot_div.sv =====
// ----------------------------------------------------------------------------
// sdot_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ----------------------------------------------------------------------------
module sdot_div import sdot_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVR_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVR_W-1:0] rem_ff, rem_in;
   logic [DVR_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVR_W:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = DVR_W'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/semi_discrete_ot_averaged_sgd.sv =====
// ----------------------------------------------------------------------------
// semi_discrete_ot_averaged_sgd: averaged SGD step for semi-discrete OT
// Streams cost columns, updates deflected and averaged dual potentials held
// in two RAMs, and emits the averages after a column flagged final.
// ----------------------------------------------------------------------------
// A cost transaction passes an accept state, then a compare against the
// deflected potential read from RAM; the block accepts nothing else while it
// works. After the last row of a column it runs a column update: C*C, the
// division by n, the square root, eta/q, then per row a RAM read, the update,
// the divider for the average step and the write back. All three divisions
// use the single shared bit-serial divider.
// After a final column the q averages leave one at a time (RAM read, load,
// output held while rsp_stall is high), with last_of_run on the final one;
// all run state then clears at once through per-row valid bits (no clearing
// pass). Configuration writes are to be made while the block is idle.
// ----------------------------------------------------------------------------
module semi_discrete_ot_averaged_sgd import sdot_pkg::*; #(
   parameter int ROWS        = DEF_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [31:0]      req_cost,
   input  logic             req_final_column,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [3:0]       rsp_potential_index,
   output logic [31:0]      rsp_potential_value,
   output logic             rsp_last_of_run,
   input  logic             csr_write,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int RW = $clog2(ROWS);         // row index
   localparam int QW = $clog2(ROWS + 1);     // row count
   localparam int NW = $clog2(MAX_COLUMNS);  // column number

   typedef enum logic [3:0] {
      S_ACCEPT, S_CMP, S_MUL, S_DIVN_GO, S_DIVN_WAIT, S_SQRT,
      S_DIVQ_GO, S_DIVQ_WAIT, S_RD, S_UPD, S_AVG_WAIT, S_ERD, S_ELD, S_EOUT
   } state_type;

   state_type             state_ff, state_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [RIU_W-1:0]      riu_ff, riu_in;
   logic [ROWS-1:0]       vld_ff, vld_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [NW-1:0]         col_ff, col_in;
   logic signed [32:0]    min_ff, min_in;
   logic [RW-1:0]         amin_ff, amin_in;
   logic [31:0]           cost_ff, cost_in;
   logic                  fin_ff, fin_in;
   logic [DIV_W-1:0]      prod_ff, prod_in;
   logic [DIV_W-1:0]      sx_ff, sx_in;
   logic [DIV_W-1:0]      sr_ff, sr_in;
   logic [DIV_W-1:0]      sbit_ff, sbit_in;
   logic [4:0]            scnt_ff, scnt_in;
   logic [DVR_W-1:0]      eta_ff, eta_in;
   logic [DVR_W-1:0]      rise_ff, rise_in;
   logic [RW-1:0]         idx_ff, idx_in;
   logic [31:0]           dn_ff, dn_in;
   logic [31:0]           v_ff, v_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ram and divider hookups
   logic [RW-1:0]         rd_addr;
   logic [31:0]           dp_rdata, av_rdata;
   logic                  wr_en;
   logic [31:0]           dp_wdata, av_wdata;
   logic                  div_start, div_done;
   logic [DIV_W-1:0]      div_dividend, div_quot;
   logic [DVR_W-1:0]      div_divisor;

   // working values
   logic [7:0]            q8;
   logic [QW-1:0]         q;
   logic [31:0]           d_rd, v_rd;
   logic signed [32:0]    diff_cmp;
   logic [33:0]           dsum;
   logic [31:0]           dnew;
   logic [32:0]           adiff, amag;
   logic [33:0]           step34;
   logic [DIV_W:0]        strial;
   logic                  last_row;

   // q clamped to the supported range
   always_comb begin
      q8 = 8'(riu_ff);
      if (q8 < 8'd2)               q8 = 8'd2;
      else if (q8 > 8'(ROWS))      q8 = 8'(ROWS);
      q = QW'(q8);
   end

   assign d_rd = vld_ff[(state_ff == S_CMP) ? row_ff : idx_ff] ? dp_rdata : 32'd0;
   assign v_rd = vld_ff[idx_ff] ? av_rdata : 32'd0;

   assign diff_cmp = $signed({cost_ff[31], cost_ff}) - $signed({d_rd[31], d_rd});

   // new deflected potential: d + eta/q, minus eta on the winning row
   assign dsum = {{2{d_rd[31]}}, d_rd} + {10'd0, rise_ff}
                 - ((idx_ff == amin_ff) ? {10'd0, eta_ff} : 34'd0);
   assign dnew = sat32($signed(dsum));

   assign adiff = {dnew[31], dnew} - {v_rd[31], v_rd};
   assign amag  = adiff[32] ? (33'd0 - adiff) : adiff;

   assign step34 = neg_ff ? (34'd0 - {1'b0, div_quot[32:0]}) : {1'b0, div_quot[32:0]};

   assign strial   = {1'b0, sx_ff} - ({1'b0, sr_ff} + {1'b0, sbit_ff});
   assign last_row = (8'(idx_ff) + 8'd1) == 8'(q);

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      riu_in       = riu_ff;
      vld_in       = vld_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      min_in       = min_ff;
      amin_in      = amin_ff;
      cost_in      = cost_ff;
      fin_in       = fin_ff;
      prod_in      = prod_ff;
      sx_in        = sx_ff;
      sr_in        = sr_ff;
      sbit_in      = sbit_ff;
      scnt_in      = scnt_ff;
      eta_in       = eta_ff;
      rise_in      = rise_ff;
      idx_in       = idx_ff;
      dn_in        = dn_ff;
      v_in         = v_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      dp_wdata     = dn_ff;
      av_wdata     = sat32($signed({{2{v_ff[31]}}, v_ff} + step34));
      div_start    = 1'b0;
      div_dividend = prod_ff;
      div_divisor  = DVR_W'(col_ff);

      if (csr_write) begin
         case (csr_index)
            CSR_STEP_GAIN:   gain_in = csr_data[GAIN_W-1:0];
            CSR_ROWS_IN_USE: riu_in  = csr_data[RIU_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_ACCEPT: begin
            rd_addr = row_ff;
            if (req_valid) begin
               cost_in  = req_cost;
               fin_in   = req_final_column;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (row_ff == '0 || diff_cmp < min_ff) begin
               min_in  = diff_cmp;
               amin_in = row_ff;
            end
            if ((8'(row_ff) + 8'd1) < 8'(q)) begin
               row_in   = row_ff + 1'b1;
               state_in = S_ACCEPT;
            end else begin
               row_in = '0;
               if (col_ff < NW'(MAX_COLUMNS - 1)) col_in = col_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = DIV_W'(gain_ff) * DIV_W'(gain_ff);
            state_in = S_DIVN_GO;
         end
         S_DIVN_GO: begin
            div_start = 1'b1;
            state_in  = S_DIVN_WAIT;
         end
         S_DIVN_WAIT: begin
            if (div_done) begin
               sx_in    = div_quot;
               sr_in    = '0;
               sbit_in  = DIV_W'(1) << (DIV_W - 2);
               scnt_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            // digit-by-digit root, two radicand bits per step
            if (!strial[DIV_W]) begin
               sx_in = strial[DIV_W-1:0];
               sr_in = (sr_ff >> 1) + sbit_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == 5'(DIV_W / 2 - 1)) begin
               eta_in   = sr_in[DVR_W-1:0];
               state_in = S_DIVQ_GO;
            end
         end
         S_DIVQ_GO: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(eta_ff);
            div_divisor  = DVR_W'(q);
            state_in     = S_DIVQ_WAIT;
         end
         S_DIVQ_WAIT: begin
            if (div_done) begin
               rise_in  = div_quot[DVR_W-1:0];
               idx_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            dn_in        = dnew;
            v_in         = v_rd;
            neg_in       = adiff[32];
            div_start    = 1'b1;
            div_dividend = DIV_W'(amag);
            state_in     = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (div_done) begin
               wr_en          = 1'b1;
               vld_in[idx_ff] = 1'b1;
               if (last_row) begin
                  idx_in   = '0;
                  state_in = fin_ff ? S_ERD : S_ACCEPT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_ERD: begin
            state_in = S_ELD;
         end
         S_ELD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = v_rd;
            rsp_last_in  = last_row;
            state_in     = S_EOUT;
         end
         S_EOUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (last_row) begin
                  // run done: run state back to its reset values, configuration kept
                  vld_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
                  min_in   = '0;
                  amin_in  = '0;
                  idx_in   = '0;
                  state_in = S_ACCEPT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCEPT;
         gain_ff      <= GAIN_W'(65536);
         riu_ff       <= RIU_W'(16);
         vld_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         min_ff       <= '0;
         amin_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         riu_ff       <= riu_in;
         vld_ff       <= vld_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         min_ff       <= min_in;
         amin_ff      <= amin_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cost_ff      <= cost_in;
      fin_ff       <= fin_in;
      prod_ff      <= prod_in;
      sx_ff        <= sx_in;
      sr_ff        <= sr_in;
      sbit_ff      <= sbit_in;
      scnt_ff      <= scnt_in;
      eta_ff       <= eta_in;
      rise_ff      <= rise_in;
      dn_ff        <= dn_in;
      v_ff         <= v_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   sdot_ram #(.WIDTH(32), .DEPTH(ROWS)) u_deflected (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (dp_wdata),
      .rd_addr (rd_addr),
      .rd_data (dp_rdata)
   );

   sdot_ram #(.WIDTH(32), .DEPTH(ROWS)) u_averaged (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (av_wdata),
      .rd_addr (rd_addr),
      .rd_data (av_rdata)
   );

   sdot_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall           = (state_ff != S_ACCEPT);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_potential_index = 4'(idx_ff);
   assign rsp_potential_value = rsp_value_ff;
   assign rsp_last_of_run     = rsp_last_ff;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for semi_discrete_ot_averaged_sgd
// Streams cost columns through the block, predicts the emitted averaged
// potentials with a cycle-free model of the update, and checks every result
// transaction in order. Runs directed corner columns, then random data sets
// under several idle/stall mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import sdot_pkg::*;

   localparam int NROWS  = DEF_ROWS;
   localparam int MAXCOL = DEF_MAX_COLUMNS;

   typedef struct {
      logic [31:0] cost;
      logic        fin;
   } cost_item_type;

   typedef struct {
      logic [3:0]  index;
      logic [31:0] value;
      logic        last;
   } potential_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [31:0]      req_cost = '0;
   logic             req_final_column = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [3:0]       rsp_potential_index;
   logic [31:0]      rsp_potential_value;
   logic             rsp_last_of_run;
   logic             csr_write = 1'b0;
   logic [IDX_W-1:0] csr_index = CSR_STEP_GAIN;
   logic [CSR_W-1:0] csr_data = '0;

   cost_item_type pending_costs[$];
   potential_type expected_potentials[$];

   int mismatches = 0;
   int costs_sent = 0;
   int potentials_seen = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   logic hold_request = 1'b0;
   logic hold_armed = 1'b0;

   // Predictor state (mirror of the block's registers and RAMs)
   logic [23:0] gain_reg;
   logic [4:0]  rows_reg;
   int          defl[NROWS];
   int          avgp[NROWS];
   int          row_cnt;
   int          col_num;
   longint      run_min;
   int          run_arg;

   always #1 clock = ~clock;

   semi_discrete_ot_averaged_sgd i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cost            (req_cost),
      .req_final_column    (req_final_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_potential_index (rsp_potential_index),
      .rsp_potential_value (rsp_potential_value),
      .rsp_last_of_run     (rsp_last_of_run),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   task automatic note_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatches++;
   endtask

   function automatic void clear_potentials();
      for (int i = 0; i < NROWS; i++) begin
         defl[i] = 0;
         avgp[i] = 0;
      end
      row_cnt = 0;
      col_num = 0;
      run_min = 0;
      run_arg = 0;
   endfunction

   function automatic int clip32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return int'(x);
   endfunction

   // Bitwise integer square root, floor
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // One accepted cost transaction: argmin tracking, column update, emission
   function automatic void predict_cost(input logic [31:0] cost, input logic fin);
      int              q, r;
      longint          diff, d, v, stp;
      longint unsigned n, g, eta, rise;
      q = rows_reg;
      if (q < 2) q = 2;
      if (q > NROWS) q = NROWS;
      r = (row_cnt >= NROWS) ? NROWS - 1 : row_cnt;
      diff = longint'($signed(cost)) - longint'(defl[r]);
      if (row_cnt == 0 || diff < run_min) begin
         run_min = diff;
         run_arg = r;
      end
      if (row_cnt + 1 < q) begin
         row_cnt++;
         return;
      end
      // column complete
      row_cnt = 0;
      if (col_num < MAXCOL - 1) col_num++;
      n = col_num;
      g = gain_reg;
      eta = floor_sqrt((g * g) / n);
      rise = eta / q;
      for (int i = 0; i < q; i++) begin
         d = longint'(defl[i]) + longint'(rise);
         if (i == run_arg) d -= longint'(eta);
         defl[i] = clip32(d);
         v = avgp[i];
         stp = (longint'(defl[i]) - v) / longint'(n);  // truncates toward zero
         avgp[i] = clip32(v + stp);
      end
      if (!fin) return;
      for (int i = 0; i < q; i++) begin
         expected_potentials.push_back('{index: i[3:0], value: avgp[i],
                                         last: (i + 1 == q)});
      end
      clear_potentials();
   endfunction

   // Driver: holds a stalled transaction, otherwise offers the next cost
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_cost(req_cost, req_final_column);
            costs_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_costs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid        <= 1'b1;
               req_cost         <= pending_costs[0].cost;
               req_final_column <= pending_costs[0].fin;
               pending_costs.pop_front();
            end else begin
               req_valid        <= 1'b0;
               req_cost         <= $urandom;
               req_final_column <= 1'($urandom_range(1));
            end
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_request && !hold_armed) begin
         hold_cycles <= 4000;
         hold_armed  <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // Monitor: random stall, compare each accepted potential
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            potentials_seen++;
            if (expected_potentials.size() == 0) begin
               note_mismatch($sformatf("unexpected potential idx %0d value %h",
                                       rsp_potential_index, rsp_potential_value));
            end else begin
               if (rsp_potential_index !== expected_potentials[0].index)
                  note_mismatch($sformatf("index got %0d want %0d", rsp_potential_index,
                                          expected_potentials[0].index));
               if (rsp_potential_value !== expected_potentials[0].value)
                  note_mismatch($sformatf("row %0d value got %h want %h",
                                          expected_potentials[0].index,
                                          rsp_potential_value,
                                          expected_potentials[0].value));
               if (rsp_last_of_run !== expected_potentials[0].last)
                  note_mismatch($sformatf("row %0d last got %b want %b",
                                          expected_potentials[0].index,
                                          rsp_last_of_run, expected_potentials[0].last));
               expected_potentials.pop_front();
            end
         end
         rsp_stall <= (hold_cycles > 1) || ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      if (idx == CSR_STEP_GAIN) gain_reg = data[23:0];
      else if (idx == CSR_ROWS_IN_USE) rows_reg = data[4:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Wait until every cost is taken and every potential has come back, then
   // cover a full column update of the largest size
   task automatic drain();
      wait (pending_costs.size() == 0);
      @(posedge clock);
      wait (!req_valid);
      wait (expected_potentials.size() == 0);
      repeat (1500) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_cost();
      case ($urandom_range(5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(8) << 14;   // small values, frequent ties
         default: return $urandom;
      endcase
   endfunction

   // One data set: a few columns, final flag on the completing entry only,
   // noise flags elsewhere
   task automatic queue_data_set(input int q, input int ncols);
      for (int c = 0; c < ncols; c++) begin
         for (int r = 0; r < q; r++) begin
            cost_item_type it;
            it.cost = pick_cost();
            if (r == q - 1) it.fin = (c == ncols - 1);
            else            it.fin = ($urandom_range(4) == 0);
            pending_costs.push_back(it);
         end
      end
   endtask

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int q, budget;
      gain_reg = 24'd65536;
      rows_reg = 5'd16;
      clear_potentials();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: smallest q with largest gain; extreme costs; ignored flag
      write_csr(CSR_STEP_GAIN, 24'hFF_FFFF);
      write_csr(CSR_ROWS_IN_USE, CSR_W'(2));
      pending_costs.push_back('{32'h7FFF_FFFF, 1'b1});
      pending_costs.push_back('{32'h8000_0000, 1'b0});
      pending_costs.push_back('{32'h0000_0005, 1'b0});  // equal costs; row 0 wins on its higher deflected potential
      pending_costs.push_back('{32'h0000_0005, 1'b1});
      drain();
      // zero gain: potentials must stay put
      write_csr(CSR_STEP_GAIN, 24'd0);
      pending_costs.push_back('{32'h0000_0000, 1'b0});
      pending_costs.push_back('{32'hFFFF_FFFF, 1'b1});
      drain();
      // q below range clamps to 2
      write_csr(CSR_STEP_GAIN, 24'd65536);
      write_csr(CSR_ROWS_IN_USE, CSR_W'(0));
      queue_data_set(2, 2);
      drain();
      // q changed mid-column: three rows in at q=8, then q=2 ends the column
      write_csr(CSR_ROWS_IN_USE, CSR_W'(8));
      for (int i = 0; i < 3; i++) pending_costs.push_back('{pick_cost(), 1'b0});
      drain();
      write_csr(CSR_ROWS_IN_USE, CSR_W'(2));
      pending_costs.push_back('{32'h0001_0000, 1'b1});
      drain();
      // q above range clamps to 16
      write_csr(CSR_ROWS_IN_USE, CSR_W'(31));
      queue_data_set(16, 1);
      drain();

      // Random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 76 : (ph == 3) ? 18 : 0;
         stall_pct     = (ph == 2) ? 76 : (ph == 3) ? 18 : 0;
         budget = 0;
         while (budget < 50) begin
            case ($urandom_range(5))
               0:       write_csr(CSR_STEP_GAIN, 24'hFF_FFFF);
               1:       write_csr(CSR_STEP_GAIN, CSR_W'($urandom_range(24'hFF_FFFF)));
               default: write_csr(CSR_STEP_GAIN, CSR_W'($urandom_range(24'h04_0000)));
            endcase
            write_csr(CSR_ROWS_IN_USE,
                      CSR_W'(($urandom_range(4) == 0) ? $urandom_range(31)
                                                       : $urandom_range(2, 6)));
            q = rows_reg;
            if (q < 2) q = 2;
            if (q > NROWS) q = NROWS;
            for (int s = 0; s < 3; s++) begin
               int nc;
               nc = $urandom_range(1, 4);
               queue_data_set(q, nc);
               budget += q * nc;
            end
            // receiver holds off while the sender keeps offering
            if (ph == 0) hold_request = 1'b1;
            drain();
         end
      end

      $display("Covered %0d cost transactions and %0d potential results,",
               costs_sent, potentials_seen);
      $display("over q from 2 to 16, gains from zero to full scale, four idle mixes.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/sdot_pkg.sv
src/sdot_ram.sv
src/sdot_div.sv
src/semi_discrete_ot_averaged_sgd.sv
test/tb_top.sv
